>>> hdl/ifd_pkg.sv
package ifd_pkg;

	// Parser states
	typedef enum logic [2:0] {
		ST_DOLLAR  = 3'd0,
		ST_CHANNEL = 3'd1,
		ST_LEN_HI  = 3'd2,
		ST_LEN_LO  = 3'd3,
		ST_PAYLOAD = 3'd4
	} parse_state_t;

	// Result kinds carried on tuser
	typedef enum logic [1:0] {
		KIND_TEXT    = 2'd0,
		KIND_START   = 2'd1,
		KIND_PAYLOAD = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MASK_LO     = 3'd0,
		REG_MASK_MID_LO = 3'd1,
		REG_MASK_MID_HI = 3'd2,
		REG_MASK_HI     = 3'd3,
		REG_TEXT_EN     = 3'd4,
		REG_DELIVER     = 3'd5
	} reg_index_t;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 16;
	localparam int MASK_W    = 64;
	localparam int IDX_W     = 3;
	localparam int KIND_W    = 2;
	localparam int OUT_W     = 2 * BYTE_W + LEN_W;

	localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CHAR_FF     = 8'hFF;
	localparam logic [BYTE_W-1:0] CHAR_FE     = 8'hFE;

endpackage

>>> hdl/interleaved_frame_deframer.sv
// Splits a received byte stream into text bytes and interleaved frames
// ('$', channel, 16-bit big-endian length, payload). One byte is taken per
// clock cycle unless the output stalls with both registers full; each byte
// passes an input register and then the parser, whose result lands in the
// output register. The output register lets a new byte be transferred while
// a finished result still waits. Results: tuser holds the kind (text byte,
// packet start, payload byte), tlast marks the final payload byte of a frame.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while no byte is in flight, the block does not enforce it.
module interleaved_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [ifd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [ifd_pkg::MASK_W-1:0]    cfg_data,
	// received bytes
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ifd_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] rx_byte
	// results
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ifd_pkg::OUT_W-1:0]     m_axis_tdata,  // [7:0] data_byte,
	                                                     // [15:8] channel_id,
	                                                     // [31:16] frame_length
	output logic [ifd_pkg::KIND_W-1:0]    m_axis_tuser,  // [1:0] kind
	output logic                          m_axis_tlast   // last_byte
);
	import ifd_pkg::*;

	// configuration
	logic [MASK_W-1:0] mask_lo_q, mask_mid_lo_q, mask_mid_hi_q, mask_hi_q;
	logic              text_en_q, deliver_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parser state
	parse_state_t      state_q, state_d;
	logic [BYTE_W-1:0] chan_q, chan_d;
	logic [BYTE_W-1:0] len_hi_q, len_hi_d;
	logic [LEN_W-1:0]  remain_q, remain_d;

	// output register
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [BYTE_W-1:0] out_data_q, out_chan_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;

	// result of the byte in the input stage
	logic              res_valid;
	kind_t             res_kind;
	logic [BYTE_W-1:0] res_data, res_chan;
	logic [LEN_W-1:0]  res_len;
	logic              res_last;

	logic              out_free, advance;
	logic              hit_byte, hit_chan, text_ok;
	logic [LEN_W-1:0]  len_full;

	// channel registration lookup
	function automatic logic chan_hit(
		input logic [BYTE_W-1:0] ch,
		input logic [MASK_W-1:0] m0,
		input logic [MASK_W-1:0] m1,
		input logic [MASK_W-1:0] m2,
		input logic [MASK_W-1:0] m3
	);
		logic [MASK_W-1:0] m;
		unique case (ch[7:6])
			2'd0:    m = m0;
			2'd1:    m = m1;
			2'd2:    m = m2;
			default: m = m3;
		endcase
		return m[ch[5:0]];
	endfunction

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign hit_byte = chan_hit(byte_s1, mask_lo_q, mask_mid_lo_q, mask_mid_hi_q, mask_hi_q);
	assign hit_chan = chan_hit(chan_q, mask_lo_q, mask_mid_lo_q, mask_mid_hi_q, mask_hi_q);
	assign text_ok  = text_en_q && (byte_s1 != CHAR_DOLLAR) && (byte_s1 != CHAR_FF)
	                  && (byte_s1 != CHAR_FE);
	assign len_full = {len_hi_q, byte_s1};

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_lo_q     <= '0;
			mask_mid_lo_q <= '0;
			mask_mid_hi_q <= '0;
			mask_hi_q     <= '0;
			text_en_q     <= 1'b0;
			deliver_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MASK_LO:     mask_lo_q     <= cfg_data;
				REG_MASK_MID_LO: mask_mid_lo_q <= cfg_data;
				REG_MASK_MID_HI: mask_mid_hi_q <= cfg_data;
				REG_MASK_HI:     mask_hi_q     <= cfg_data;
				REG_TEXT_EN:     text_en_q     <= cfg_data[0];
				REG_DELIVER:     deliver_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// capture each transfer in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// next parser state
	always_comb begin
		state_d  = state_q;
		chan_d   = chan_q;
		len_hi_d = len_hi_q;
		remain_d = remain_q;
		unique case (state_q)
			ST_CHANNEL: begin
				if (hit_byte) begin
					chan_d  = byte_s1;
					state_d = ST_LEN_HI;
				end else begin
					state_d = ST_DOLLAR;
				end
			end
			ST_LEN_HI: begin
				len_hi_d = byte_s1;
				state_d  = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				if (!hit_chan) begin
					state_d = ST_DOLLAR;
				end else begin
					remain_d = len_full;
					state_d  = (len_full == '0) ? ST_DOLLAR : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				if (!hit_chan || remain_q == '0) begin
					state_d = (byte_s1 == CHAR_DOLLAR) ? ST_CHANNEL : ST_DOLLAR;
				end else begin
					remain_d = remain_q - LEN_W'(1);
					if (remain_q == LEN_W'(1)) begin
						state_d = ST_DOLLAR;
					end
				end
			end
			default: begin
				state_d = (byte_s1 == CHAR_DOLLAR) ? ST_CHANNEL : ST_DOLLAR;
			end
		endcase
	end

	// result of the current byte
	always_comb begin
		res_valid = 1'b0;
		res_kind  = KIND_TEXT;
		res_data  = byte_s1;
		res_chan  = '0;
		res_len   = '0;
		res_last  = 1'b0;
		unique case (state_q)
			ST_CHANNEL, ST_LEN_HI: begin
				res_valid = 1'b0;
			end
			ST_LEN_LO: begin
				res_valid = hit_chan;
				res_kind  = KIND_START;
				res_data  = '0;
				res_chan  = chan_q;
				res_len   = len_full;
			end
			ST_PAYLOAD: begin
				if (!hit_chan || remain_q == '0) begin
					res_valid = text_ok;
				end else begin
					res_valid = deliver_q;
					res_kind  = KIND_PAYLOAD;
					res_chan  = chan_q;
					res_last  = (remain_q == LEN_W'(1));
				end
			end
			default: begin
				res_valid = text_ok;
			end
		endcase
	end

	// advance the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DOLLAR;
			chan_q   <= '0;
			len_hi_q <= '0;
			remain_q <= '0;
		end else if (advance) begin
			state_q  <= state_d;
			chan_q   <= chan_d;
			len_hi_q <= len_hi_d;
			remain_q <= remain_d;
		end
	end

	// hold the result until it is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_kind_q <= res_kind;
			out_data_q <= res_data;
			out_chan_q <= res_chan;
			out_len_q  <= res_len;
			out_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_chan_q, out_data_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// a frame in payload always has bytes left
	a_payload_remain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAYLOAD |-> remain_q != '0)
		else $error("payload state with no bytes remaining");

	// tlast only on payload bytes
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PAYLOAD)
		else $error("tlast on a non-payload result");

	// text bytes carry no channel and no length
	a_text_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_TEXT |->
			m_axis_tdata[OUT_W-1:BYTE_W] == '0)
		else $error("text result with channel or length set");

	// an empty output register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output register empty");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ifd_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_BYTES   = 100;
	localparam int MAX_REPORTS   = 30;

	// indexes past the last register; writes to them must have no effect
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		kind_t            kind;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] chan;
		logic [LEN_W-1:0]  len;
		logic              last;
	} deframe_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 cfg_we = 1'b0;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [MASK_W-1:0]    cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic [KIND_W-1:0]    m_axis_tuser;
	logic                 m_axis_tlast;

	// predictor copy of the registers and the parser
	logic [MASK_W-1:0]    chan_mask [4] = '{default: '0};
	logic                 text_en = 1'b0;
	logic                 deliver = 1'b1;
	parse_state_t         pstate = ST_DOLLAR;
	logic [BYTE_W-1:0]    fchan = '0;
	logic [BYTE_W-1:0]    len_hi = '0;
	logic [LEN_W-1:0]     remain = '0;

	deframe_result_t      pending_results [$];
	int                   errors = 0;
	int                   bytes_sent = 0;
	bit                   no_idle = 1'b0;
	int                   hold_seq = 0;
	int                   hold_seen = 0;
	int                   hold_left = 0;
	int                   stall_left = 0;
	int unsigned          cycle_count = 0;

	interleaved_frame_deframer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic bit chan_on(logic [BYTE_W-1:0] ch);
		return chan_mask[ch[7:6]][ch[5:0]];
	endfunction

	function automatic void push_result(kind_t k, logic [BYTE_W-1:0] d,
			logic [BYTE_W-1:0] c, logic [LEN_W-1:0] l, logic last);
		deframe_result_t r;
		r.kind = k;
		r.data = d;
		r.chan = c;
		r.len  = l;
		r.last = last;
		pending_results.push_back(r);
	endfunction

	// hunt for '$'; pass other bytes as text unless disabled or filler
	function automatic void hunt_dollar(logic [BYTE_W-1:0] c);
		pstate = ST_DOLLAR;
		if (c == CHAR_DOLLAR)
			pstate = ST_CHANNEL;
		else if (text_en && c != CHAR_FF && c != CHAR_FE)
			push_result(KIND_TEXT, c, '0, '0, 1'b0);
	endfunction

	// advance the parser by one byte and queue the result it yields
	function automatic void predict_byte(logic [BYTE_W-1:0] c);
		logic [LEN_W-1:0] len;
		case (pstate)
			ST_CHANNEL: begin
				if (chan_on(c)) begin
					fchan  = c;
					pstate = ST_LEN_HI;
				end else begin
					pstate = ST_DOLLAR;
				end
			end
			ST_LEN_HI: begin
				len_hi = c;
				pstate = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				if (!chan_on(fchan)) begin
					pstate = ST_DOLLAR;
				end else begin
					len    = {len_hi, c};
					remain = len;
					pstate = (len == '0) ? ST_DOLLAR : ST_PAYLOAD;
					push_result(KIND_START, '0, fchan, len, 1'b0);
				end
			end
			ST_PAYLOAD: begin
				if (!chan_on(fchan) || remain == '0) begin
					hunt_dollar(c);
				end else begin
					remain = remain - LEN_W'(1);
					if (remain == '0)
						pstate = ST_DOLLAR;
					if (deliver)
						push_result(KIND_PAYLOAD, c, fchan, '0, remain == '0);
				end
			end
			default: hunt_dollar(c);
		endcase
	endfunction

	// offer one byte after a random gap; predict once it is transferred
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		predict_byte(b);
		bytes_sent++;
	endtask

	// stop sending and wait for every expected result plus pipeline slack
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MASK_LO:     chan_mask[0] = val;
			REG_MASK_MID_LO: chan_mask[1] = val;
			REG_MASK_MID_HI: chan_mask[2] = val;
			REG_MASK_HI:     chan_mask[3] = val;
			REG_TEXT_EN:     text_en = val[0];
			REG_DELIVER:     deliver = val[0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [MASK_W-1:0] m0, m1, m2, m3,
			input logic ten, input logic dlv);
		write_reg(REG_MASK_LO, m0);
		write_reg(REG_MASK_MID_LO, m1);
		write_reg(REG_MASK_MID_HI, m2);
		write_reg(REG_MASK_HI, m3);
		write_reg(REG_TEXT_EN, {{(MASK_W-1){1'b0}}, ten});
		write_reg(REG_DELIVER, {{(MASK_W-1){1'b0}}, dlv});
	endtask

	function automatic logic [BYTE_W-1:0] pick_channel(bit want_on);
		logic [BYTE_W-1:0] ch;
		for (int i = 0; i < 32; i++) begin
			ch = BYTE_W'($urandom_range(0, 255));
			if (chan_on(ch) == want_on)
				return ch;
		end
		return ch;
	endfunction

	function automatic logic [MASK_W-1:0] random_mask();
		logic [MASK_W-1:0] a;
		logic [MASK_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 2))
			0:       return a & b;
			1:       return a | b;
			default: return a;
		endcase
	endfunction

	// text filtering, frames of each length class, unregistered channel
	task automatic test_directed();
		logic [BYTE_W-1:0] seq [$];
		seq = '{8'h00, 8'h7F, CHAR_FE, CHAR_FF, 8'h80,
			CHAR_DOLLAR, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55,
			CHAR_DOLLAR, 8'hC0, 8'h00, 8'h00,
			CHAR_DOLLAR, 8'hFF, 8'h41,
			CHAR_DOLLAR, 8'h80, 8'hFF, 8'hFF, 8'h01};
		// every channel but the top one
		load_config('1, '1, '1, {1'b0, {(MASK_W-1){1'b1}}}, 1'b1, 1'b1);
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// drop a channel while its frame is in payload, then while in the header
	task automatic test_unregister_mid_frame();
		settle();
		write_reg(REG_MASK_MID_HI, {{(MASK_W-1){1'b1}}, 1'b0});
		send_byte(CHAR_DOLLAR);
		send_byte(8'h41);
		send_byte(8'h00);
		settle();
		write_reg(REG_MASK_MID_LO, '0);
		send_byte(8'h03);
		send_byte(8'h42);
	endtask

	// stall the output long enough for the input to back up
	task automatic test_backpressure();
		logic [BYTE_W-1:0] b;
		settle();
		write_reg(REG_TEXT_EN, {{(MASK_W-1){1'b0}}, 1'b1});
		no_idle = 1'b1;
		hold_seq++;
		for (int i = 0; i < 40; i++) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (b == CHAR_DOLLAR)
				b = CHAR_FF;
			send_byte(b);
		end
		no_idle = 1'b0;
		settle();
	endtask

	// mostly well-formed frames with random content, plus noise and bad headers
	task automatic test_random_phases();
		int first;
		int pick;
		int len;
		logic [BYTE_W-1:0] ch;
		logic [BYTE_W-1:0] b;
		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0:       load_config('1, '1, '1, '1, 1'b1, 1'b1);
				1:       load_config('0, '0, '0, '0, 1'b1, 1'b0);
				default: load_config(random_mask(), random_mask(), random_mask(),
						random_mask(), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			endcase
			no_idle = (p == 3);
			first = bytes_sent;
			while (bytes_sent - first < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					ch  = pick_channel(1'b1);
					len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 60)
						: $urandom_range(0, 8);
					send_byte(CHAR_DOLLAR);
					send_byte(ch);
					send_byte(len[15:8]);
					send_byte(len[7:0]);
					for (int k = 0; k < len; k++)
						send_byte(BYTE_W'($urandom_range(0, 255)));
				end else if (pick < 85) begin
					case ($urandom_range(0, 3))
						0:       b = CHAR_FE;
						1:       b = CHAR_FF;
						default: b = BYTE_W'($urandom_range(0, 255));
					endcase
					if (b == CHAR_DOLLAR)
						b = CHAR_FE;
					send_byte(b);
				end else begin
					ch = pick_channel(1'b0);
					if (!chan_on(ch)) begin
						send_byte(CHAR_DOLLAR);
						send_byte(ch);
					end
				end
			end
		end
		no_idle = 1'b0;
	endtask

	// output side: random stall after each transfer, long hold on request
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (m_axis_tvalid && m_axis_tready)
			stall_left = draw_gap();
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		deframe_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual kind %0d data %h",
						$time, m_axis_tuser, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
				check_field("data_byte", 32'(want.data), 32'(m_axis_tdata[7:0]));
				check_field("channel_id", 32'(want.chan), 32'(m_axis_tdata[15:8]));
				check_field("frame_length", 32'(want.len), 32'(m_axis_tdata[31:16]));
				check_field("last_byte", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	// end a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_unregister_mid_frame();
		test_backpressure();
		test_random_phases();
		settle();
		if (errors == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/ifd_pkg.sv
hdl/interleaved_frame_deframer.sv
sim/tb_top.sv
